### src/pcdeb_pkg.sv
// Shared constants and types for the per-input counter debounce block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package pcdeb_pkg;

  localparam int NUM_INPUTS    = 13;
  localparam int FIELD_BITS    = 13;
  localparam int ACTIVE_INPUTS = (NUM_INPUTS < FIELD_BITS) ? NUM_INPUTS : FIELD_BITS;
  localparam int THR_W         = 16;
  localparam int THR_PER_REG   = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;

  typedef logic [FIELD_BITS-1:0]               level_vec_t;
  typedef logic [ACTIVE_INPUTS-1:0]            active_vec_t;
  typedef logic [THR_W-1:0]                    thr_t;
  typedef logic [ACTIVE_INPUTS-1:0][THR_W-1:0] thr_arr_t;
  typedef logic [CFG_IDX_W-1:0]                cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]               cfg_data_t;

  localparam thr_t THR_MAX = {THR_W{1'b1}};

endpackage

### src/pcdeb_if.sv
// Valid/ready channel interfaces for the debounce block: input, result, config.
// Depends on pcdeb_pkg.
`timescale 1ns / 1ps

interface pcdeb_in_if import pcdeb_pkg::*; ();
  logic       valid;
  logic       ready;
  level_vec_t raw_levels;
  modport source (output valid, output raw_levels, input ready);
  modport sink   (input valid, input raw_levels, output ready);
endinterface

interface pcdeb_out_if import pcdeb_pkg::*; ();
  logic       valid;
  logic       ready;
  level_vec_t filtered_levels;
  modport source (output valid, output filtered_levels, input ready);
  modport sink   (input valid, input filtered_levels, output ready);
endinterface

interface pcdeb_cfg_if import pcdeb_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  idx;
  cfg_data_t wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

### src/pcdeb_cfg_regs.sv
// Threshold register file: one 16-bit debounce threshold per active input.
// Depends on pcdeb_pkg.
`timescale 1ns / 1ps

module pcdeb_cfg_regs import pcdeb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  cfg_idx_t  wr_idx,
  input  cfg_data_t wr_data,
  output thr_arr_t  thr
);

  thr_arr_t thr_r;

  // Input i lives in register i/4, slot i%4; writes beyond the last register match nothing.
  for (genvar i = 0; i < ACTIVE_INPUTS; i++) begin : g_thr
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        thr_r[i] <= '0;
      end else if (wr_en && (wr_idx == CFG_IDX_W'(i / THR_PER_REG))) begin
        thr_r[i] <= wr_data[(i % THR_PER_REG) * THR_W +: THR_W];
      end
    end
  end

  assign thr = thr_r;

endmodule

### src/pcdeb_filter.sv
// Debounce state and per-input update: stable levels and mismatch counters.
// Depends on pcdeb_pkg.
`timescale 1ns / 1ps

module pcdeb_filter import pcdeb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  level_vec_t raw,
  input  thr_arr_t   thr,
  output level_vec_t stable_nxt_out
);

  active_vec_t                   stable_r;
  active_vec_t                   stable_nxt;
  logic [ACTIVE_INPUTS-1:0][THR_W-1:0] cnt_r;
  logic [ACTIVE_INPUTS-1:0][THR_W-1:0] cnt_nxt;

  for (genvar i = 0; i < ACTIVE_INPUTS; i++) begin : g_ch
    logic differ;
    thr_t inc;
    logic hit;

    assign differ = raw[i] ^ stable_r[i];
    // The counter saturates rather than wrapping.
    assign inc    = (cnt_r[i] == THR_MAX) ? cnt_r[i] : cnt_r[i] + thr_t'(1);
    assign hit    = (inc >= thr[i]);

    always_comb begin
      stable_nxt[i] = stable_r[i];
      cnt_nxt[i]    = '0;
      if (differ) begin
        if (hit) begin
          stable_nxt[i] = raw[i];
        end else begin
          cnt_nxt[i] = inc;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stable_r[i] <= 1'b0;
        cnt_r[i]    <= '0;
      end else if (step_en) begin
        stable_r[i] <= stable_nxt[i];
        cnt_r[i]    <= cnt_nxt[i];
      end
    end
  end

  // Inputs past the active count are not filtered and read as zero.
  for (genvar b = 0; b < FIELD_BITS; b++) begin : g_out
    if (b < ACTIVE_INPUTS) begin : g_act
      assign stable_nxt_out[b] = stable_nxt[b];
    end else begin : g_off
      assign stable_nxt_out[b] = 1'b0;
    end
  end

endmodule

### src/per_input_counter_debounce_top.sv
// Top level of the per-input counter debounce filter.
// Depends on pcdeb_pkg, pcdeb_if, pcdeb_cfg_regs and pcdeb_filter.
//
//   Channel  Direction  Payload                       Transaction when
//   in_ch    sink       raw_levels[12:0]              valid && ready
//   out_ch   source     filtered_levels[12:0]         valid && ready
//   cfg_ch   sink       idx[2:0], wdata[63:0]         valid && ready
//
// Each transaction is held in the input register and then moves to the result
// register, from which out_ch offers it; one item is taken per cycle while out_ch
// does not stall. All thirteen counters update in parallel with one compare each.
// Reset (rst_n low, synchronous) clears thresholds, stable levels, counters and
// both valid flags.
// A stalled result holds the pipeline; the input register still fills behind it.
// Config is always ready.
`timescale 1ns / 1ps

module per_input_counter_debounce_top import pcdeb_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  pcdeb_in_if.sink   in_ch,
  pcdeb_out_if.source out_ch,
  pcdeb_cfg_if.sink  cfg_ch
);

  logic       in_vld_r;
  level_vec_t in_raw_r;
  logic       out_vld_r;
  level_vec_t out_lvl_r;
  logic       out_free;
  logic       step;
  thr_arr_t   thr;
  level_vec_t stable_nxt;

  assign out_free     = !out_vld_r || out_ch.ready;
  assign step         = in_vld_r && out_free;
  assign in_ch.ready  = !in_vld_r || out_free;
  assign cfg_ch.ready = 1'b1;

  pcdeb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.idx),
    .wr_data (cfg_ch.wdata),
    .thr     (thr)
  );

  pcdeb_filter u_filter (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step),
    .raw            (in_raw_r),
    .thr            (thr),
    .stable_nxt_out (stable_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_raw_r <= in_ch.raw_levels;
    end
    if (step) begin
      out_lvl_r <= stable_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.filtered_levels = out_lvl_r;

endmodule

### bench/tb.sv
// Self-checking testbench for per_input_counter_debounce_top.
// Depends on pcdeb_pkg and the channel interfaces in pcdeb_if, plus the RTL top.
`timescale 1ns / 1ps

module tb;
  import pcdeb_pkg::*;

  localparam cfg_idx_t REG_THR_0_3  = 3'd0;
  localparam cfg_idx_t REG_THR_4_7  = 3'd1;
  localparam cfg_idx_t REG_THR_8_11 = 3'd2;
  localparam cfg_idx_t REG_THR_12   = 3'd3;
  localparam cfg_idx_t REG_UNUSED_4 = 3'd4;
  localparam cfg_idx_t REG_UNUSED_7 = 3'd7;
  localparam int NUM_CFG_REGS = 4;
  localparam level_vec_t ALL_HIGH = {FIELD_BITS{1'b1}};
  localparam cfg_data_t LANE_MASK = 64'h0000_0000_0000_FFFF;

  logic clk;
  logic rst_n;

  pcdeb_in_if  in_ch ();
  pcdeb_out_if out_ch ();
  pcdeb_cfg_if cfg_ch ();

  per_input_counter_debounce_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted state of the filter, updated at every accepted transaction.
  level_vec_t stable_model;
  thr_t       count_model [ACTIVE_INPUTS];
  cfg_data_t  thr_regs_model [NUM_CFG_REGS];
  level_vec_t expected_levels [$];

  int error_count;
  int items_sent;
  int results_checked;
  int cfg_writes;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", expected_levels.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic thr_t threshold_for(int lane);
    cfg_data_t v;
    int        sh;
    v  = thr_regs_model[lane / THR_PER_REG];
    sh = (lane % THR_PER_REG) * THR_W;
    if ((lane / THR_PER_REG) == REG_THR_12) begin
      v &= LANE_MASK;
    end
    return v[sh +: THR_W];
  endfunction

  function automatic level_vec_t debounce_step(level_vec_t raw);
    level_vec_t st;
    thr_t       c;
    st = stable_model;
    for (int i = 0; i < ACTIVE_INPUTS; i++) begin
      if (raw[i] != st[i]) begin
        c = count_model[i];
        if (c != THR_MAX) begin
          c = c + 1'b1;
        end
        if (c >= threshold_for(i)) begin
          st[i] = raw[i];
          c = '0;
        end
        count_model[i] = c;
      end else begin
        count_model[i] = '0;
      end
    end
    stable_model = st;
    return st;
  endfunction

  task automatic report_mismatch(string what, level_vec_t want, level_vec_t got);
    $display("[%0t] MISMATCH %s: expected %h got %h", $realtime, what, want, got);
    error_count++;
  endtask

  // Model updates and result checking, all sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_writes++;
        if (cfg_ch.idx < NUM_CFG_REGS) begin
          thr_regs_model[cfg_ch.idx] <= (cfg_ch.idx == REG_THR_12) ?
                                        (cfg_ch.wdata & LANE_MASK) : cfg_ch.wdata;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected result", '0, out_ch.filtered_levels);
        end else begin
          level_vec_t want;
          want = expected_levels.pop_front();
          results_checked++;
          if (out_ch.filtered_levels !== want) begin
            report_mismatch("filtered_levels", want, out_ch.filtered_levels);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        items_sent++;
        expected_levels.push_back(debounce_step(in_ch.raw_levels));
      end
    end
  end

  // Result-side ready: random stalls plus an optional long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_levels(level_vec_t raw);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.raw_levels <= raw;
    // Ready has settled by the falling edge and holds until the next rising edge.
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all_thresholds(thr_t thr);
    cfg_write(REG_THR_0_3,  {4{thr}});
    cfg_write(REG_THR_4_7,  {4{thr}});
    cfg_write(REG_THR_8_11, {4{thr}});
    cfg_write(REG_THR_12,   {48'hFFFF_FFFF_FFFF, thr});
  endtask

  function automatic thr_t random_threshold();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return thr_t'($urandom_range(8));
    else if (pick < 90) return thr_t'($urandom_range(65535));
    else return THR_MAX;
  endfunction

  task automatic randomize_thresholds();
    cfg_data_t v;
    for (int r = 0; r < NUM_CFG_REGS; r++) begin
      v = {random_threshold(), random_threshold(), random_threshold(), random_threshold()};
      // Register 3 keeps only its low lane; load the rest with junk.
      if (r == REG_THR_12) begin
        v[63:16] = 48'({$urandom, $urandom});
      end
      cfg_write(cfg_idx_t'(r), v);
    end
  endtask

  // With zero thresholds every difference is taken on the first sample.
  task automatic test_threshold_zero();
    send_levels('0);
    send_levels(ALL_HIGH);
    send_levels('0);
    send_levels(13'h1555);
    send_levels(13'h0AAA);
    wait_drain();
  endtask

  task automatic test_threshold_one();
    set_all_thresholds(16'd1);
    send_levels('0);
    send_levels(ALL_HIGH);
    send_levels(13'h0F0F);
    wait_drain();
  endtask

  // A matching sample in the middle of a run must clear the count.
  task automatic test_count_and_clear();
    set_all_thresholds(16'd3);
    send_levels('0);
    send_levels('0);
    send_levels(ALL_HIGH);
    send_levels('0);
    send_levels('0);
    send_levels('0);
    wait_drain();
  endtask

  // Counts already past a newly lowered threshold flip on the next mismatch.
  task automatic test_threshold_lowered();
    set_all_thresholds(16'd6);
    repeat (4) send_levels(ALL_HIGH);
    wait_drain();
    set_all_thresholds(16'd2);
    send_levels(ALL_HIGH);
    wait_drain();
  endtask

  task automatic test_max_threshold_and_ignored_index();
    for (int r = 0; r < NUM_CFG_REGS; r++) begin
      cfg_write(cfg_idx_t'(r), '1);
    end
    send_levels('0);
    send_levels(13'h1234);
    wait_drain();
    // Writes beyond the last register must leave thresholds untouched.
    cfg_write(REG_UNUSED_4, '0);
    cfg_write(REG_UNUSED_7, '0);
    send_levels('0);
    send_levels(ALL_HIGH);
    wait_drain();
    for (int r = 0; r < NUM_CFG_REGS; r++) begin
      cfg_write(cfg_idx_t'(r), '0);
    end
    send_levels(13'h0001);
    send_levels(13'h1000);
    wait_drain();
  endtask

  // Hold results off while the sender keeps offering, then drain fully.
  task automatic test_backpressure();
    randomize_thresholds();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 150;
    for (int n = 0; n < 24; n++) begin
      send_levels(level_vec_t'($urandom));
    end
    wait_drain();
  endtask

  // Mostly steady runs of a target vector with occasional single-bit bounces and random samples.
  task automatic run_random_items(int count, int s_pct, int r_pct);
    level_vec_t target;
    level_vec_t raw;
    int         run_len;
    int         sent;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    randomize_thresholds();
    sent = 0;
    while (sent < count) begin
      target  = level_vec_t'($urandom);
      run_len = $urandom_range(12, 1);
      for (int k = 0; k < run_len && sent < count; k++) begin
        raw = target;
        if ($urandom_range(99) < 20) begin
          raw[$urandom_range(FIELD_BITS - 1)] ^= 1'b1;
        end else if ($urandom_range(99) < 5) begin
          raw = level_vec_t'($urandom);
        end
        send_levels(raw);
        sent++;
      end
      if ($urandom_range(99) < 10) begin
        wait_drain();
        randomize_thresholds();
      end
    end
    wait_drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.raw_levels = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.idx       = '0;
    cfg_ch.wdata     = '0;
    error_count      = 0;
    items_sent       = 0;
    results_checked  = 0;
    cfg_writes       = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_left        = 0;
    stable_model     = '0;
    for (int i = 0; i < ACTIVE_INPUTS; i++) count_model[i] = '0;
    for (int r = 0; r < NUM_CFG_REGS; r++) thr_regs_model[r] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 67;
    test_threshold_zero();
    test_threshold_one();
    test_count_and_clear();
    test_threshold_lowered();
    test_max_threshold_and_ignored_index();
    test_backpressure();
    run_random_items(240, 11, 67);
    run_random_items(240, 67, 11);
    run_random_items(240, 0, 0);

    wait_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d sampling ticks, checked %0d filtered results, %0d register writes.",
             items_sent, results_checked, cfg_writes);
    $display("Covered zero, one, lowered and maximum thresholds, ignored indexes and stalls.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### per_input_counter_debounce_top.f
src/pcdeb_pkg.sv
src/pcdeb_if.sv
src/pcdeb_cfg_regs.sv
src/pcdeb_filter.sv
src/per_input_counter_debounce_top.sv
bench/tb.sv
